// ===== hw/rtl/mdbh_pkg.sv =====
// ----------------------------------------------------------------------------
// mdbh_pkg
// Shared types and constants for the baseline-tracking metal detector.
// ----------------------------------------------------------------------------
package mdbh_pkg;

	localparam int DISC_W = 12;
	localparam int CNT_W  = 13;
	localparam int SUM_W  = 24;
	localparam int WGT_W  = 17;
	localparam int RUN_W  = 8;
	localparam int IDX_W  = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(65536);
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	localparam logic [1:0] MODE_CAL      = 2'd0;
	localparam logic [1:0] MODE_NONE     = 2'd1;
	localparam logic [1:0] MODE_DETECTED = 2'd2;

	localparam logic [IDX_W-1:0] CFG_DISCARD     = 3'd0;
	localparam logic [IDX_W-1:0] CFG_CALIBRATION = 3'd1;
	localparam logic [IDX_W-1:0] CFG_BASE_WEIGHT = 3'd2;
	localparam logic [IDX_W-1:0] CFG_OUT_WEIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_DETECT_LVL  = 3'd4;
	localparam logic [IDX_W-1:0] CFG_RELEASE_LVL = 3'd5;
	localparam logic [IDX_W-1:0] CFG_DETECT_RUN  = 3'd6;
	localparam logic [IDX_W-1:0] CFG_RELEASE_RUN = 3'd7;

	typedef struct packed {
		logic [DISC_W-1:0] discard_count;
		logic [CNT_W-1:0]  calibration_count;
		logic [WGT_W-1:0]  baseline_weight;
		logic [WGT_W-1:0]  output_weight;
		logic [RUN_W-1:0]  detect_run_needed;
		logic [RUN_W-1:0]  release_run_needed;
	} mdbh_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_BM0,
		ST_BM1,
		ST_BM2,
		ST_SHIFT,
		ST_SM0,
		ST_SM1,
		ST_SM2,
		ST_MODE,
		ST_OUT
	} back_state_t;

endpackage

// ===== hw/rtl/metal_detect_baseline_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// metal_detect_baseline_hysteresis_unit
// Baseline-tracking metal detector: calibration mean, baseline and output
// moving averages, debounced hysteresis decision.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   input    | push / full           | sample
//   result   | pop / empty           | filtered_level, baseline_level,
//            |                       | detect_state
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample at a time through the engine: once calibrated it runs two
// multiply-accumulates on the shared multiplier; during discard it skips the
// baseline update, and while averaging the bit-serial divider forms the mean.
// The first sample after reset skips the smoother. A two-beat input queue
// takes samples while the engine works; a one-beat result register holds a
// result until popped, and the engine waits in its last step while it is
// occupied. Reset clears all filter state; cfg_ready is always high.
// ----------------------------------------------------------------------------
module metal_detect_baseline_hysteresis_unit #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	output logic                                     full,
	input  logic [SAMPLE_BITS-1:0]                   sample,
	output logic                                     empty,
	input  logic                                     pop,
	output logic signed [SAMPLE_BITS+FRACTION_BITS:0] filtered_level,
	output logic [SAMPLE_BITS+FRACTION_BITS-1:0]     baseline_level,
	output logic [1:0]                               detect_state,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [mdbh_pkg::IDX_W-1:0]               cfg_index,
	input  logic [((SAMPLE_BITS+FRACTION_BITS+1) > 17 ?
		(SAMPLE_BITS+FRACTION_BITS+1) : 17)-1:0]        cfg_data
);

	localparam int SLW = SAMPLE_BITS + FRACTION_BITS + 1;

	mdbh_pkg::mdbh_cfg_t     cfg;
	logic signed [SLW-1:0]   detect_level;
	logic signed [SLW-1:0]   release_level;
	logic                    q_valid;
	logic [SAMPLE_BITS-1:0]  q_sample;
	logic                    q_pop;

	mdbh_front #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cfg           (cfg),
		.detect_level  (detect_level),
		.release_level (release_level),
		.q_valid       (q_valid),
		.q_sample      (q_sample),
		.q_pop         (q_pop)
	);

	mdbh_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.detect_level   (detect_level),
		.release_level  (release_level),
		.q_valid        (q_valid),
		.q_sample       (q_sample),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.filtered_level (filtered_level),
		.baseline_level (baseline_level),
		.detect_state   (detect_state)
	);

endmodule

// ===== hw/rtl/mdbh_front.sv =====
// ----------------------------------------------------------------------------
// mdbh_front
// Register file and two-entry sample queue in front of the filter engine.
// ----------------------------------------------------------------------------
module mdbh_front #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mdbh_pkg::IDX_W-1:0]        cfg_index,
	input  logic [((SAMPLE_BITS+FRACTION_BITS+1) > 17 ?
		(SAMPLE_BITS+FRACTION_BITS+1) : 17)-1:0] cfg_data,
	output mdbh_pkg::mdbh_cfg_t               cfg,
	output logic signed [SAMPLE_BITS+FRACTION_BITS:0] detect_level,
	output logic signed [SAMPLE_BITS+FRACTION_BITS:0] release_level,
	output logic                              q_valid,
	output logic [SAMPLE_BITS-1:0]            q_sample,
	input  logic                              q_pop
);

	localparam int SLW = SAMPLE_BITS + FRACTION_BITS + 1;

	mdbh_pkg::mdbh_cfg_t          cfg_q;
	logic signed [SLW-1:0]        det_lvl_q;
	logic signed [SLW-1:0]        rel_lvl_q;
	logic [SAMPLE_BITS-1:0]       slot_q [2];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [1:0]                   count_q;
	logic                         wr_en;
	logic                         rd_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.discard_count      <= mdbh_pkg::DISC_W'(10);
			cfg_q.calibration_count  <= mdbh_pkg::CNT_W'(100);
			cfg_q.baseline_weight    <= mdbh_pkg::WGT_W'(66);
			cfg_q.output_weight      <= mdbh_pkg::WGT_W'(16384);
			cfg_q.detect_run_needed  <= mdbh_pkg::RUN_W'(3);
			cfg_q.release_run_needed <= mdbh_pkg::RUN_W'(3);
			det_lvl_q                <= SLW'(12800);
			rel_lvl_q                <= SLW'(6400);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mdbh_pkg::CFG_DISCARD:
					cfg_q.discard_count <= cfg_data[mdbh_pkg::DISC_W-1:0];
				mdbh_pkg::CFG_CALIBRATION:
					cfg_q.calibration_count <= cfg_data[mdbh_pkg::CNT_W-1:0];
				mdbh_pkg::CFG_BASE_WEIGHT:
					cfg_q.baseline_weight <= cfg_data[mdbh_pkg::WGT_W-1:0];
				mdbh_pkg::CFG_OUT_WEIGHT:
					cfg_q.output_weight <= cfg_data[mdbh_pkg::WGT_W-1:0];
				mdbh_pkg::CFG_DETECT_LVL:
					det_lvl_q <= $signed(cfg_data[SLW-1:0]);
				mdbh_pkg::CFG_RELEASE_LVL:
					rel_lvl_q <= $signed(cfg_data[SLW-1:0]);
				mdbh_pkg::CFG_DETECT_RUN:
					cfg_q.detect_run_needed <= cfg_data[mdbh_pkg::RUN_W-1:0];
				mdbh_pkg::CFG_RELEASE_RUN:
					cfg_q.release_run_needed <= cfg_data[mdbh_pkg::RUN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg           = cfg_q;
	assign detect_level  = det_lvl_q;
	assign release_level = rel_lvl_q;

	assign full     = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_sample = slot_q[rd_ptr_q];
	assign wr_en    = push && !full;
	assign rd_en    = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= sample;
		end
	end

endmodule

// ===== hw/rtl/mdbh_back.sv =====
// ----------------------------------------------------------------------------
// mdbh_back
// Sequenced filter engine: calibration mean by a bit-serial divider, two
// moving averages on one shared multiplier, debounced hysteresis decision,
// and the result register.
// ----------------------------------------------------------------------------
module mdbh_back #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  mdbh_pkg::mdbh_cfg_t                      cfg,
	input  logic signed [SAMPLE_BITS+FRACTION_BITS:0] detect_level,
	input  logic signed [SAMPLE_BITS+FRACTION_BITS:0] release_level,
	input  logic                                     q_valid,
	input  logic [SAMPLE_BITS-1:0]                   q_sample,
	output logic                                     q_pop,
	output logic                                     empty,
	input  logic                                     pop,
	output logic signed [SAMPLE_BITS+FRACTION_BITS:0] filtered_level,
	output logic [SAMPLE_BITS+FRACTION_BITS-1:0]     baseline_level,
	output logic [1:0]                               detect_state
);

	localparam int LW  = SAMPLE_BITS + FRACTION_BITS;
	localparam int SLW = LW + 1;
	localparam int PW  = SLW + mdbh_pkg::WGT_W + 1;
	localparam int AW  = PW + 1;
	localparam int DW  = mdbh_pkg::SUM_W + FRACTION_BITS + 1;
	localparam int NW  = mdbh_pkg::CNT_W;
	localparam int DCW = $clog2(DW);
	localparam logic [AW-1:0] RND = AW'(32768);

	mdbh_pkg::back_state_t state_q, state_d;

	// persistent filter state
	logic [NW-1:0]                   cnt_q;
	logic [mdbh_pkg::SUM_W-1:0]      sum_q;
	logic [LW-1:0]                   baseline_q;
	logic signed [SLW-1:0]           smoothed_q;
	logic                            seeded_q;
	logic                            cal_q;
	logic [1:0]                      mode_q;
	logic [mdbh_pkg::RUN_W-1:0]      hit_q;
	logic [mdbh_pkg::RUN_W-1:0]      miss_q;

	// per-item scratch
	logic [SAMPLE_BITS-1:0]          raw_q;
	logic signed [SLW-1:0]           shift_q;
	logic [DW-1:0]                   dvd_q;
	logic [NW-1:0]                   div_q;
	logic [NW-1:0]                   rem_q;
	logic [DCW-1:0]                  div_cnt_q;
	logic signed [PW-1:0]            prod_q;
	logic signed [AW-1:0]            acc_q;

	// result register
	logic                            out_valid_q;
	logic signed [SLW-1:0]           out_filt_q;
	logic [LW-1:0]                   out_base_q;
	logic [1:0]                      out_mode_q;
	logic                            out_load;

	logic [NW-1:0]                   cnt_n;
	logic                            past_discard;
	logic [mdbh_pkg::SUM_W:0]        sum_wide;
	logic [mdbh_pkg::SUM_W-1:0]      sum_n;
	logic [NW-1:0]                   n_cal;
	logic [DW-1:0]                   dividend;
	logic [NW:0]                     rem_sh;
	logic [NW:0]                     rem_trial;
	logic                            rem_ge;
	logic [DW-1:0]                   dvd_n;
	logic [NW-1:0]                   rem_n;
	logic [mdbh_pkg::WGT_W-1:0]      wb_c;
	logic [mdbh_pkg::WGT_W-1:0]      wo_c;
	logic [mdbh_pkg::WGT_W-1:0]      mul_w;
	logic signed [SLW-1:0]           mul_x;
	logic signed [PW-1:0]            prod;
	logic signed [AW-1:0]            blend_sum;
	logic signed [SLW-1:0]           fresh;
	logic signed [SLW-1:0]           shifted;
	logic [1:0]                      mode_d;
	logic [mdbh_pkg::RUN_W-1:0]      hit_d;
	logic [mdbh_pkg::RUN_W-1:0]      miss_d;
	logic                            lvl_hit;

	// calibration bookkeeping
	assign cnt_n        = (cnt_q < mdbh_pkg::CNT_MAX) ? cnt_q + NW'(1) : cnt_q;
	assign past_discard = cnt_n > NW'(cfg.discard_count);
	assign sum_wide     = {1'b0, sum_q} + (mdbh_pkg::SUM_W + 1)'(raw_q);
	assign sum_n        = sum_wide[mdbh_pkg::SUM_W] ? mdbh_pkg::SUM_MAX :
		sum_wide[mdbh_pkg::SUM_W-1:0];
	assign n_cal        = cnt_n - NW'(cfg.discard_count);
	assign dividend     = DW'({sum_n, {FRACTION_BITS{1'b0}}}) + DW'(n_cal >> 1);

	// restoring divider, one quotient bit per cycle
	assign rem_sh    = {rem_q, dvd_q[DW-1]};
	assign rem_trial = rem_sh - {1'b0, div_q};
	assign rem_ge    = rem_sh >= {1'b0, div_q};
	assign rem_n     = rem_ge ? rem_trial[NW-1:0] : rem_sh[NW-1:0];
	assign dvd_n     = {dvd_q[DW-2:0], rem_ge};

	// shared multiplier
	assign wb_c  = (cfg.baseline_weight > mdbh_pkg::WGT_ONE) ? mdbh_pkg::WGT_ONE :
		cfg.baseline_weight;
	assign wo_c  = (cfg.output_weight > mdbh_pkg::WGT_ONE) ? mdbh_pkg::WGT_ONE :
		cfg.output_weight;
	assign fresh = $signed({1'b0, raw_q, {FRACTION_BITS{1'b0}}});

	always_comb begin
		mul_w = wo_c;
		mul_x = shift_q;
		case (state_q)
			mdbh_pkg::ST_BM0: begin
				mul_w = wb_c;
				mul_x = fresh;
			end
			mdbh_pkg::ST_BM1: begin
				mul_w = mdbh_pkg::WGT_ONE - wb_c;
				mul_x = $signed({1'b0, baseline_q});
			end
			mdbh_pkg::ST_SM1: begin
				mul_w = mdbh_pkg::WGT_ONE - wo_c;
				mul_x = smoothed_q;
			end
			default: begin
				mul_w = wo_c;
				mul_x = shift_q;
			end
		endcase
	end

	assign prod      = $signed({1'b0, mul_w}) * mul_x;
	assign blend_sum = acc_q + AW'(prod_q);
	assign shifted   = fresh - $signed({1'b0, baseline_q});

	// debounced hysteresis on the fresh smoothed level
	always_comb begin
		mode_d  = mode_q;
		hit_d   = hit_q;
		miss_d  = miss_q;
		lvl_hit = 1'b0;
		if (!cal_q) begin
			mode_d = mdbh_pkg::MODE_CAL;
			hit_d  = '0;
			miss_d = '0;
		end else begin
			if (mode_d == mdbh_pkg::MODE_CAL) begin
				mode_d = mdbh_pkg::MODE_NONE;
				hit_d  = '0;
				miss_d = '0;
			end
			if (mode_d == mdbh_pkg::MODE_DETECTED) begin
				lvl_hit = (release_level > 0) ? (smoothed_q < release_level) :
					(smoothed_q > release_level);
				if (lvl_hit) begin
					if (miss_d != mdbh_pkg::RUN_MAX) begin
						miss_d = miss_d + 1'b1;
					end
					if (miss_d >= cfg.release_run_needed) begin
						mode_d = mdbh_pkg::MODE_NONE;
						hit_d  = '0;
						miss_d = '0;
					end
				end else begin
					miss_d = '0;
				end
			end else if (mode_d == mdbh_pkg::MODE_NONE) begin
				lvl_hit = (detect_level > 0) ? (smoothed_q > detect_level) :
					(smoothed_q < detect_level);
				if (lvl_hit) begin
					if (hit_d != mdbh_pkg::RUN_MAX) begin
						hit_d = hit_d + 1'b1;
					end
					if (hit_d >= cfg.detect_run_needed) begin
						mode_d = mdbh_pkg::MODE_DETECTED;
						hit_d  = '0;
						miss_d = '0;
					end
				end else begin
					hit_d = '0;
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdbh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			mdbh_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = mdbh_pkg::ST_PREP;
				end
			end
			mdbh_pkg::ST_PREP: begin
				if (cal_q) begin
					state_d = mdbh_pkg::ST_BM0;
				end else if (past_discard) begin
					state_d = mdbh_pkg::ST_DIV;
				end else begin
					state_d = mdbh_pkg::ST_SHIFT;
				end
			end
			mdbh_pkg::ST_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = mdbh_pkg::ST_SHIFT;
				end
			end
			mdbh_pkg::ST_BM0:   state_d = mdbh_pkg::ST_BM1;
			mdbh_pkg::ST_BM1:   state_d = mdbh_pkg::ST_BM2;
			mdbh_pkg::ST_BM2:   state_d = mdbh_pkg::ST_SHIFT;
			mdbh_pkg::ST_SHIFT: state_d = seeded_q ? mdbh_pkg::ST_SM0 : mdbh_pkg::ST_MODE;
			mdbh_pkg::ST_SM0:   state_d = mdbh_pkg::ST_SM1;
			mdbh_pkg::ST_SM1:   state_d = mdbh_pkg::ST_SM2;
			mdbh_pkg::ST_SM2:   state_d = mdbh_pkg::ST_MODE;
			mdbh_pkg::ST_MODE:  state_d = mdbh_pkg::ST_OUT;
			mdbh_pkg::ST_OUT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = mdbh_pkg::ST_IDLE;
				end
			end
			default: state_d = mdbh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sum_q       <= '0;
			baseline_q  <= '0;
			smoothed_q  <= '0;
			seeded_q    <= 1'b0;
			cal_q       <= 1'b0;
			mode_q      <= mdbh_pkg::MODE_CAL;
			hit_q       <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				mdbh_pkg::ST_PREP: begin
					if (!cal_q) begin
						cnt_q <= cnt_n;
						if (past_discard) begin
							sum_q <= sum_n;
							if (cnt_n >= cfg.calibration_count) begin
								cal_q <= 1'b1;
							end
						end
					end
				end
				mdbh_pkg::ST_DIV: begin
					if (div_cnt_q == '0) begin
						baseline_q <= dvd_n[LW-1:0];
					end
				end
				mdbh_pkg::ST_BM2: baseline_q <= blend_sum[LW+15:16];
				mdbh_pkg::ST_SHIFT: begin
					if (!seeded_q) begin
						smoothed_q <= shifted;
						seeded_q   <= 1'b1;
					end
				end
				mdbh_pkg::ST_SM2: smoothed_q <= blend_sum[SLW+15:16];
				mdbh_pkg::ST_MODE: begin
					mode_q <= mode_d;
					hit_q  <= hit_d;
					miss_q <= miss_d;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mdbh_pkg::ST_IDLE: raw_q <= q_sample;
			mdbh_pkg::ST_PREP: begin
				dvd_q     <= dividend;
				div_q     <= n_cal;
				rem_q     <= '0;
				div_cnt_q <= DCW'(DW - 1);
			end
			mdbh_pkg::ST_DIV: begin
				dvd_q     <= dvd_n;
				rem_q     <= rem_n;
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			mdbh_pkg::ST_BM0, mdbh_pkg::ST_SM0: prod_q <= prod;
			mdbh_pkg::ST_BM1, mdbh_pkg::ST_SM1: begin
				acc_q  <= AW'(prod_q) + RND;
				prod_q <= prod;
			end
			mdbh_pkg::ST_SHIFT: shift_q <= shifted;
			default: begin
			end
		endcase
		if (out_load) begin
			out_filt_q <= smoothed_q;
			out_base_q <= baseline_q;
			out_mode_q <= mode_q;
		end
	end

	assign empty          = !out_valid_q;
	assign filtered_level = out_filt_q;
	assign baseline_level = out_base_q;
	assign detect_state   = out_mode_q;

endmodule

// ===== hw/rtl/mdbh_checker.sv =====
// ----------------------------------------------------------------------------
// mdbh_checker
// Port-level checks for the metal detector, bound to the top level.
// ----------------------------------------------------------------------------
module mdbh_checker #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 8
) (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     push,
	input logic                                     full,
	input logic [SAMPLE_BITS-1:0]                   sample,
	input logic                                     empty,
	input logic                                     pop,
	input logic signed [SAMPLE_BITS+FRACTION_BITS:0] filtered_level,
	input logic [SAMPLE_BITS+FRACTION_BITS-1:0]     baseline_level,
	input logic [1:0]                               detect_state,
	input logic                                     cfg_valid,
	input logic                                     cfg_ready,
	input logic [mdbh_pkg::IDX_W-1:0]               cfg_index,
	input logic [((SAMPLE_BITS+FRACTION_BITS+1) > 17 ?
		(SAMPLE_BITS+FRACTION_BITS+1) : 17)-1:0]       cfg_data
);

	logic left_cal_q;

	// set once a popped beat shows calibration finished
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_cal_q <= 1'b0;
		end else if (pop && !empty && detect_state != mdbh_pkg::MODE_CAL) begin
			left_cal_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(filtered_level) &&
			$stable(baseline_level) && $stable(detect_state)))
		else $error("result beat changed while stalled");

	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

	a_no_recal: assert property (@(posedge clk) disable iff (!arst_n)
		(left_cal_q && !empty) |-> (detect_state != mdbh_pkg::MODE_CAL))
		else $error("detector returned to calibration");

	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (detect_state == mdbh_pkg::MODE_CAL ||
			detect_state == mdbh_pkg::MODE_NONE ||
			detect_state == mdbh_pkg::MODE_DETECTED))
		else $error("unused detect state code on result");

endmodule

bind metal_detect_baseline_hysteresis_unit mdbh_checker #(
	.SAMPLE_BITS   (SAMPLE_BITS),
	.FRACTION_BITS (FRACTION_BITS)
) u_mdbh_checker (.*);

// ===== tb/sv/tb_metal_detect_baseline_hysteresis_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_metal_detect_baseline_hysteresis_unit
// Self-checking bench for the metal detector. A bit-exact software copy of
// the calibration mean, both moving averages and the debounced detector
// predicts every result beat. It starts with directed calibration and
// weight cases. Random rounds follow: each has its own register setting
// and idle pattern, and it drives quiet stretches, target bursts and noise.
// ----------------------------------------------------------------------------
module tb_metal_detect_baseline_hysteresis_unit;
	import mdbh_pkg::*;

	localparam int SMP_W         = 12;
	localparam int FRAC_W        = 8;
	localparam int LVL_W         = SMP_W + FRAC_W + 1;
	localparam int BASE_W        = SMP_W + FRAC_W;
	localparam int DATA_W        = LVL_W;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 64;
	localparam int LVL_MIN       = -1048576;
	localparam int LVL_MAX       = 1048575;
	localparam longint Q16_ONE   = 65536;

	typedef struct packed {
		logic [LVL_W-1:0]  level;
		logic [BASE_W-1:0] base;
		logic [1:0]        mode;
	} reading_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    push      = 1'b0;
	logic                    full;
	logic [SMP_W-1:0]        sample    = '0;
	logic                    empty;
	logic                    pop       = 1'b0;
	logic signed [LVL_W-1:0] filtered_level;
	logic [BASE_W-1:0]       baseline_level;
	logic [1:0]              detect_state;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [DATA_W-1:0]       cfg_data  = '0;

	int gap_pct     = 0;
	int stall_pct   = 0;
	int errors      = 0;
	int cycle_count = 0;

	// detector copy
	mdbh_cfg_t        regs;
	int               detect_thr;
	int               release_thr;
	logic [CNT_W-1:0] seen_count;
	logic [SUM_W-1:0] cal_sum;
	longint           base_q;
	longint           smooth_q;
	logic             smooth_seeded;
	logic             is_calibrated;
	logic [1:0]       det_mode;
	logic [RUN_W-1:0] hit_run;
	logic [RUN_W-1:0] clear_run;

	reading_t pending_readings[$];

	metal_detect_baseline_hysteresis_unit #(
		.SAMPLE_BITS  (SMP_W),
		.FRACTION_BITS(FRAC_W)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.empty         (empty),
		.pop           (pop),
		.filtered_level(filtered_level),
		.baseline_level(baseline_level),
		.detect_state  (detect_state),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_beat
		reading_t exp;
		if (arst_n && pop && !empty) begin
			if (pending_readings.size() == 0) begin
				note_mismatch($sformatf("unexpected beat level=%0d base=%0d state=%0d",
					filtered_level, baseline_level, detect_state));
			end else begin
				exp = pending_readings.pop_front();
				if (filtered_level !== exp.level || baseline_level !== exp.base ||
						detect_state !== exp.mode)
					note_mismatch($sformatf(
						"level %0d/%0d base %0d/%0d state %0d/%0d (got/exp)",
						filtered_level, $signed(exp.level), baseline_level, exp.base,
						detect_state, exp.mode));
			end
		end
	end

	function automatic longint ema(input logic [WGT_W-1:0] w_raw, input longint fresh,
			input longint old);
		longint w;
		w = (w_raw > WGT_ONE) ? Q16_ONE : longint'(w_raw);
		return (w * fresh + (Q16_ONE - w) * old + 32768) >>> 16;
	endfunction

	task automatic reset_detector_model();
		regs.discard_count      = DISC_W'(10);
		regs.calibration_count  = CNT_W'(100);
		regs.baseline_weight    = WGT_W'(66);
		regs.output_weight      = WGT_W'(16384);
		regs.detect_run_needed  = RUN_W'(3);
		regs.release_run_needed = RUN_W'(3);
		detect_thr    = 12800;
		release_thr   = 6400;
		seen_count    = '0;
		cal_sum       = '0;
		base_q        = 0;
		smooth_q      = 0;
		smooth_seeded = 1'b0;
		is_calibrated = 1'b0;
		det_mode      = MODE_CAL;
		hit_run       = '0;
		clear_run     = '0;
	endtask

	task automatic track_sample(input logic [SMP_W-1:0] raw, output reading_t exp);
		longint         raw_q;
		longint         shifted;
		longint         n;
		logic [SUM_W:0] wide_sum;
		logic           hit;
		raw_q = longint'(raw) <<< FRAC_W;
		if (is_calibrated) begin
			base_q = ema(regs.baseline_weight, raw_q, base_q);
		end else begin
			if (seen_count < CNT_MAX)
				seen_count++;
			if (seen_count > regs.discard_count) begin
				n = longint'(seen_count) - longint'(regs.discard_count);
				wide_sum = cal_sum + raw;
				cal_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
				base_q = ((longint'(cal_sum) <<< FRAC_W) + n / 2) / n;
				if (seen_count >= regs.calibration_count)
					is_calibrated = 1'b1;
			end
		end

		shifted = raw_q - base_q;
		if (!smooth_seeded) begin
			smooth_q = shifted;
			smooth_seeded = 1'b1;
		end else begin
			smooth_q = ema(regs.output_weight, shifted, smooth_q);
		end

		if (!is_calibrated) begin
			det_mode = MODE_CAL;
			hit_run = '0;
			clear_run = '0;
		end else begin
			// calibration end: enter none, then test the same beat
			if (det_mode == MODE_CAL) begin
				det_mode = MODE_NONE;
				hit_run = '0;
				clear_run = '0;
			end
			if (det_mode == MODE_DETECTED) begin
				hit = (release_thr > 0) ? (smooth_q < release_thr) : (smooth_q > release_thr);
				if (hit) begin
					if (clear_run < RUN_MAX)
						clear_run++;
					if (clear_run >= regs.release_run_needed) begin
						det_mode = MODE_NONE;
						hit_run = '0;
						clear_run = '0;
					end
				end else begin
					clear_run = '0;
				end
			end else if (det_mode == MODE_NONE) begin
				hit = (detect_thr > 0) ? (smooth_q > detect_thr) : (smooth_q < detect_thr);
				if (hit) begin
					if (hit_run < RUN_MAX)
						hit_run++;
					if (hit_run >= regs.detect_run_needed) begin
						det_mode = MODE_DETECTED;
						hit_run = '0;
						clear_run = '0;
					end
				end else begin
					hit_run = '0;
				end
			end
		end

		exp.level = smooth_q[LVL_W-1:0];
		exp.base  = base_q[BASE_W-1:0];
		exp.mode  = det_mode;
	endtask

	task automatic send_sample(input logic [SMP_W-1:0] raw);
		reading_t exp;
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		sample <= raw;
		do @(posedge clk); while (full);
		track_sample(raw, exp);
		pending_readings.push_back(exp);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_DISCARD:     regs.discard_count      = value[DISC_W-1:0];
			CFG_CALIBRATION: regs.calibration_count  = value[CNT_W-1:0];
			CFG_BASE_WEIGHT: regs.baseline_weight    = value[WGT_W-1:0];
			CFG_OUT_WEIGHT:  regs.output_weight      = value[WGT_W-1:0];
			CFG_DETECT_LVL:  detect_thr              = $signed(value);
			CFG_RELEASE_LVL: release_thr             = $signed(value);
			CFG_DETECT_RUN:  regs.detect_run_needed  = value[RUN_W-1:0];
			CFG_RELEASE_RUN: regs.release_run_needed = value[RUN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// reset values: ten beats dropped, then the mean starts
	task automatic test_reset_calibration();
		logic [SMP_W-1:0] pat [12] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800,
			12'h7FF, 12'hFFE, 12'h123, 12'hABC, 12'hFFF, 12'h000};
		gap_pct = 0;
		stall_pct = 0;
		foreach (pat[i])
			send_sample(pat[i]);
		wait_drained();
	endtask

	// discard raised past the count: baseline held at its nonzero mean
	task automatic test_discard_hold();
		write_reg(CFG_DISCARD, DATA_W'(4095));
		write_reg(CFG_CALIBRATION, DATA_W'(4096));
		gap_pct = 69;
		repeat (3)
			send_sample(SMP_W'($urandom));
		wait_drained();
	endtask

	task automatic test_long_average();
		write_reg(CFG_DISCARD, DATA_W'(0));
		stall_pct = 69;
		gap_pct = 0;
		repeat (5)
			send_sample(SMP_W'($urandom));
		wait_drained();
	endtask

	// count below counter: next beat calibrates and is tested for detect
	task automatic test_calibration_end();
		write_reg(CFG_DETECT_RUN, DATA_W'(0));
		write_reg(CFG_DETECT_LVL, DATA_W'(1));
		write_reg(CFG_RELEASE_LVL, DATA_W'(LVL_MIN));
		write_reg(CFG_RELEASE_RUN, DATA_W'(255));
		write_reg(CFG_CALIBRATION, DATA_W'(1));
		gap_pct = 0;
		stall_pct = 0;
		send_sample(12'hFFF);
		send_sample(12'h000);
		send_sample(12'hFFF);
		send_sample(SMP_W'($urandom));
		wait_drained();
	endtask

	task automatic test_weight_limits();
		write_reg(CFG_RELEASE_LVL, DATA_W'(LVL_MAX));
		write_reg(CFG_RELEASE_RUN, DATA_W'(0));
		write_reg(CFG_BASE_WEIGHT, DATA_W'(131071));
		write_reg(CFG_OUT_WEIGHT, DATA_W'(131071));
		send_sample(12'h3C5);
		send_sample(12'hC3A);
		wait_drained();
		write_reg(CFG_BASE_WEIGHT, DATA_W'(0));
		write_reg(CFG_OUT_WEIGHT, DATA_W'(0));
		send_sample(12'h000);
		send_sample(12'hFFF);
		wait_drained();
	endtask

	function automatic int pick_level(input int pol, input int lo, input int hi);
		int mag;
		mag = int'($urandom_range(hi, lo)) * 256 + int'($urandom_range(255));
		case ($urandom_range(19))
			0: return LVL_MIN;
			1: return LVL_MAX;
			2: return 0;
			default: return pol * mag;
		endcase
	endfunction

	task automatic test_random_detection(input int gap, input int stall, input int count);
		int pol;
		int center;
		int offset;
		int seg_len;
		int kind;
		int v;
		int sent;
		pol = $urandom_range(1) ? 1 : -1;
		case ($urandom_range(9))
			0: write_reg(CFG_BASE_WEIGHT, DATA_W'(0));
			1: write_reg(CFG_BASE_WEIGHT, DATA_W'(65536));
			2: write_reg(CFG_BASE_WEIGHT, DATA_W'($urandom_range(131071, 65537)));
			default: write_reg(CFG_BASE_WEIGHT, DATA_W'($urandom_range(4000, 1)));
		endcase
		case ($urandom_range(9))
			0: write_reg(CFG_OUT_WEIGHT, DATA_W'(65536));
			1: write_reg(CFG_OUT_WEIGHT, DATA_W'($urandom_range(131071, 65537)));
			default: write_reg(CFG_OUT_WEIGHT, DATA_W'($urandom_range(60000, 2000)));
		endcase
		write_reg(CFG_DETECT_LVL, DATA_W'(pick_level(pol, 50, 600)));
		write_reg(CFG_RELEASE_LVL, DATA_W'(pick_level(pol, 0, 300)));
		case ($urandom_range(9))
			0: write_reg(CFG_DETECT_RUN, DATA_W'(255));
			1: write_reg(CFG_DETECT_RUN, DATA_W'(0));
			default: write_reg(CFG_DETECT_RUN, DATA_W'($urandom_range(5, 1)));
		endcase
		case ($urandom_range(9))
			0: write_reg(CFG_RELEASE_RUN, DATA_W'(255));
			1: write_reg(CFG_RELEASE_RUN, DATA_W'(0));
			default: write_reg(CFG_RELEASE_RUN, DATA_W'($urandom_range(5, 1)));
		endcase
		write_reg(CFG_DISCARD, DATA_W'($urandom));
		write_reg(CFG_CALIBRATION, DATA_W'($urandom_range(4096, 1)));

		gap_pct = gap;
		stall_pct = stall;
		center = $urandom_range(3600, 400);
		sent = 0;
		while (sent < count) begin
			seg_len = $urandom_range(12, 1);
			kind = $urandom_range(9);
			offset = 0;
			if (kind >= 5) begin
				offset = $urandom_range(900, 50);
				if ($urandom_range(4) == 0)
					offset = -offset;
				offset = pol * offset;
			end
			repeat (seg_len) begin
				if (kind == 0)
					v = $urandom_range(4095);
				else
					v = center + offset + int'($urandom_range(40)) - 20;
				v = (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
				send_sample(SMP_W'(v));
				sent++;
			end
		end
		wait_drained();
	endtask

	initial begin
		reset_detector_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_discard_hold();
		test_long_average();
		test_calibration_end();
		test_weight_limits();
		test_random_detection(0, 0, 150);
		test_random_detection(69, 0, 150);
		test_random_detection(0, 69, 150);
		test_random_detection(35, 35, 150);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/mdbh_pkg.sv
hw/rtl/mdbh_front.sv
hw/rtl/mdbh_back.sv
hw/rtl/metal_detect_baseline_hysteresis_unit.sv
hw/rtl/mdbh_checker.sv
tb/sv/tb_metal_detect_baseline_hysteresis_unit.sv
